// File: rtl/qslerp_pkg.sv
// qslerp_pkg: shared constants and the arctangent table for the slerp datapath
// no dependencies
package qslerp_pkg;

  localparam int FracOne     = 16384;
  localparam int AngW        = 20;
  localparam int CordicSteps = 16;
  localparam int RootW       = 17;
  localparam int QuoW        = 31;

  localparam logic [16:0]            AngHalfPi     = 17'd102944;
  localparam logic [17:0]            AngPi         = 18'd205887;
  localparam logic signed [AngW-1:0] CordicGainInv = 20'sd39797;

  function automatic logic signed [AngW-1:0] atan_at(input logic [3:0] idx);
    logic signed [AngW-1:0] a;
    case (idx)
      4'd0:    a = 20'sd51472;
      4'd1:    a = 20'sd30386;
      4'd2:    a = 20'sd16055;
      4'd3:    a = 20'sd8150;
      4'd4:    a = 20'sd4091;
      4'd5:    a = 20'sd2047;
      4'd6:    a = 20'sd1024;
      4'd7:    a = 20'sd512;
      4'd8:    a = 20'sd256;
      4'd9:    a = 20'sd128;
      4'd10:   a = 20'sd64;
      4'd11:   a = 20'sd32;
      4'd12:   a = 20'sd16;
      4'd13:   a = 20'sd8;
      4'd14:   a = 20'sd4;
      default: a = 20'sd2;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/quaternion_slerp.sv
// quaternion_slerp: fixed-point quaternion slerp, top level
// depends on qslerp_pkg, qslerp_isqrt, qslerp_vec, qslerp_sin, qslerp_div
//
// One transaction in, one out; a new transaction is taken every cycle unless
// the output stalls. The whole pipeline advances together: it moves whenever
// the output register is empty or being taken, so in_ready_o follows
// out_ready_i. Most of the depth lies in the 17-stage square root, two 16-stage
// cordics and the 31-stage divider. The small-angle threshold thr_q is written through cfg_we_i.
module quaternion_slerp import qslerp_pkg::*; #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [14:0]                cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [COMPONENT_WIDTH-1:0] first_w_i,
  input  logic signed [COMPONENT_WIDTH-1:0] first_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] first_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] first_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0] second_w_i,
  input  logic signed [COMPONENT_WIDTH-1:0] second_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] second_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] second_z_i,
  input  logic [14:0]                blend_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [COMPONENT_WIDTH-1:0] out_w_o,
  output logic signed [COMPONENT_WIDTH-1:0] out_x_o,
  output logic signed [COMPONENT_WIDTH-1:0] out_y_o,
  output logic signed [COMPONENT_WIDTH-1:0] out_z_o
);

  localparam int W     = COMPONENT_WIDTH;
  localparam int PW    = 4 * (W + 1);
  localparam int QV    = 4 * W;
  localparam int SumW  = 2 * W + 2;
  localparam int MagW  = (SumW > 30) ? SumW : 30;
  localparam int AccW  = W + 34;
  localparam int SideC = PW + QV + 15 + 17;
  localparam int SideV = PW + QV + 15 + 17 + 1;
  localparam int SideS = PW + QV + 15 + 17 + 2;
  localparam int SideD = PW + QV + 15 + 2;

  localparam logic signed [AccW-1:0] SatHi = AccW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [AccW-1:0] SatLo = ~SatHi;

  function automatic logic [16:0] fold_arg(input logic [18:0] m);
    logic signed [19:0] r;
    r = $signed({1'b0, m});
    if (r > $signed({3'b000, AngHalfPi})) r = $signed({2'b00, AngPi}) - r;
    if (r < 0) r = '0;
    return r[16:0];
  endfunction

  function automatic logic [16:0] clamp_sine(input logic signed [AngW-1:0] y);
    logic [16:0] r;
    if (y < 0) r = '0;
    else if (y > 20'sd65536) r = 17'd65536;
    else r = y[16:0];
    return r;
  endfunction

  logic        en;
  logic [14:0] thr_q;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 15'd2;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // stage a: products
  logic [3:0][W-1:0]   p_in, q_in;
  logic                va_q;
  logic [3:0][W-1:0]   pa_q, qa_q;
  logic [14:0]         ta_q;
  logic [3:0][2*W-1:0] prod_q;

  assign p_in = {first_z_i, first_y_i, first_x_i, first_w_i};
  assign q_in = {second_z_i, second_y_i, second_x_i, second_w_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q <= p_in;
      qa_q <= q_in;
      ta_q <= blend_i;
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= $signed(p_in[k]) * $signed(q_in[k]);
      end
    end
  end

  // stage b: dot product, shortest arc, clamp and round
  logic signed [SumW-1:0] dot;
  logic                   neg;
  logic [MagW-1:0]        mag, magc;
  logic [16:0]            dval;
  logic [3:0][W:0]        pn;
  logic                   vb_q;
  logic [3:0][W:0]        pb_q;
  logic [3:0][W-1:0]      qb_q;
  logic [14:0]            tb_q;
  logic [16:0]            db_q;

  always_comb begin
    dot = '0;
    for (int k = 0; k < 4; k++) begin
      dot = dot + SumW'($signed(prod_q[k]));
    end
  end

  assign neg  = dot[SumW-1];
  assign mag  = MagW'(neg ? -dot : dot);
  assign magc = (mag > (MagW'(1) << 28)) ? (MagW'(1) << 28) : mag;
  assign dval = 17'((magc + MagW'(2048)) >> 12);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pn[k] = neg ? (W+1)'(-$signed({pa_q[k][W-1], pa_q[k]})) : {pa_q[k][W-1], pa_q[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pb_q <= pn;
      qb_q <= qa_q;
      tb_q <= ta_q;
      db_q <= dval;
    end
  end

  // stage c: radicand 1 - d^2
  logic             vc_q;
  logic [32:0]      radc_q;
  logic [SideC-1:0] sidec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      radc_q  <= 33'((34'd1 << 32) - 34'(db_q) * 34'(db_q));
      sidec_q <= {pb_q, qb_q, tb_q, db_q};
    end
  end

  // square root
  logic             sq_valid;
  logic [RootW-1:0] s1;
  logic [SideC-1:0] sq_side;
  logic [PW-1:0]    p1;
  logic [QV-1:0]    q1;
  logic [14:0]      t1;
  logic [16:0]      d1;
  logic             lin1;

  qslerp_isqrt #(.SideW(SideC)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vc_q),
    .rad_i   (radc_q),
    .side_i  (sidec_q),
    .valid_o (sq_valid),
    .root_o  (s1),
    .side_o  (sq_side)
  );

  assign {p1, q1, t1, d1} = sq_side;
  assign lin1 = (s1 == '0) || (s1 < {thr_q, 2'b00});

  // arc angle
  logic                   vec_valid;
  logic signed [AngW-1:0] z_v;
  logic [SideV-1:0]       vec_side;
  logic [PW-1:0]          p2;
  logic [QV-1:0]          q2;
  logic [14:0]            t2;
  logic [16:0]            s2;
  logic                   lin2;

  qslerp_vec #(.SideW(SideV)) u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .x_i     (d1),
    .y_i     (s1),
    .side_i  ({p1, q1, t1, s1, lin1}),
    .valid_o (vec_valid),
    .z_o     (z_v),
    .side_o  (vec_side)
  );

  assign {p2, q2, t2, s2, lin2} = vec_side;

  // stage d: sine arguments
  logic [16:0]        ang;
  logic signed [16:0] fa;
  logic [14:0]        maga;
  logic               vd_q;
  logic [18:0]        arga_q, argb_q;
  logic [SideS-1:0]   sided_q;

  assign ang  = z_v[AngW-1] ? '0 : ((z_v > $signed({3'b000, AngHalfPi})) ? AngHalfPi : z_v[16:0]);
  assign fa   = 17'(FracOne) - $signed({2'b00, t2});
  assign maga = fa[16] ? 15'(-fa) : fa[14:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en) begin
      vd_q <= vec_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      arga_q  <= 19'((33'(maga) * 33'(ang) + 33'd8192) >> 14);
      argb_q  <= 19'((33'(t2) * 33'(ang) + 33'd8192) >> 14);
      sided_q <= {p2, q2, t2, s2, lin2, fa[16]};
    end
  end

  // sines
  logic                   sin_valid;
  logic signed [AngW-1:0] sin_a, sin_b;
  logic [SideS-1:0]       sin_side;
  logic [PW-1:0]          p3;
  logic [QV-1:0]          q3;
  logic [14:0]            t3;
  logic [16:0]            s3;
  logic                   lin3, neg3;
  logic [QuoW-1:0]        num_a, num_b;
  logic [16:0]            den;

  qslerp_sin #(.SideW(SideS)) u_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vd_q),
    .arg_a_i (fold_arg(arga_q)),
    .arg_b_i (fold_arg(argb_q)),
    .side_i  (sided_q),
    .valid_o (sin_valid),
    .sin_a_o (sin_a),
    .sin_b_o (sin_b),
    .side_o  (sin_side)
  );

  assign {p3, q3, t3, s3, lin3, neg3} = sin_side;
  assign num_a = {clamp_sine(sin_a), 14'b0} + QuoW'(s3 >> 1);
  assign num_b = {clamp_sine(sin_b), 14'b0} + QuoW'(s3 >> 1);
  assign den   = (s3 == '0) ? 17'd1 : s3;

  // weights
  logic             div_valid;
  logic [QuoW-1:0]  quo_a, quo_b;
  logic [SideD-1:0] div_side;
  logic [3:0][W:0]  p4;
  logic [3:0][W-1:0] q4;
  logic [14:0]      t4;
  logic             lin4, neg4;

  qslerp_div #(.SideW(SideD)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sin_valid),
    .num_a_i (num_a),
    .num_b_i (num_b),
    .den_i   (den),
    .side_i  ({p3, q3, t3, lin3, neg3}),
    .valid_o (div_valid),
    .quo_a_o (quo_a),
    .quo_b_o (quo_b),
    .side_o  (div_side)
  );

  assign {p4, q4, t4, lin4, neg4} = div_side;

  // stage f: weighted components
  logic signed [31:0]  wa, wb;
  logic                vf_q;
  logic [3:0][W+32:0]  ma_q, mb_q;

  always_comb begin
    if (lin4) begin
      wa = 32'(FracOne) - $signed({17'b0, t4});
      wb = $signed({17'b0, t4});
    end else begin
      wa = neg4 ? -$signed({1'b0, quo_a}) : $signed({1'b0, quo_a});
      wb = $signed({1'b0, quo_b});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en) begin
      vf_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        ma_q[k] <= $signed(p4[k]) * wa;
        mb_q[k] <= $signed(q4[k]) * wb;
      end
    end
  end

  // stage g: round, saturate, output register
  logic [3:0][W-1:0] res;
  logic              vg_q;
  logic [3:0][W-1:0] out_q;

  always_comb begin
    logic signed [AccW-1:0] acc;
    logic signed [AccW-1:0] sh;
    for (int k = 0; k < 4; k++) begin
      acc = AccW'($signed(ma_q[k])) + AccW'($signed(mb_q[k])) + AccW'(8192);
      sh  = acc >>> 14;
      if (sh > SatHi) res[k] = SatHi[W-1:0];
      else if (sh < SatLo) res[k] = SatLo[W-1:0];
      else res[k] = sh[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else if (en) begin
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = vg_q;
  assign out_w_o     = out_q[0];
  assign out_x_o     = out_q[1];
  assign out_y_o     = out_q[2];
  assign out_z_o     = out_q[3];

  a_dot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q |-> db_q <= 17'd65536)
    else $error("rounded dot product out of range");

  a_root_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid |-> s1 <= 17'd65536)
    else $error("square root above one");

  a_stall_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_q))
    else $error("pending transaction lost during stall");

endmodule

// File: rtl/qslerp_isqrt.sv
// qslerp_isqrt: pipelined integer square root, one root bit per stage
// depends on qslerp_pkg
module qslerp_isqrt import qslerp_pkg::*; #(
  parameter int SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [32:0]      rad_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output logic [SideW-1:0] side_o
);

  localparam int Steps = RootW;

  logic [33:0]      rem_q  [Steps];
  logic [RootW-1:0] root_q [Steps];
  logic             vld_q  [Steps];
  logic [SideW-1:0] side_q [Steps];

  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam int K = Steps - 1 - j;
    logic [33:0]      rem_in;
    logic [RootW-1:0] root_in;
    logic             vld_in;
    logic [SideW-1:0] side_in;
    logic [35:0]      trial;
    logic             fits;

    if (j == 0) begin : g_head
      assign rem_in  = {1'b0, rad_i};
      assign root_in = '0;
      assign vld_in  = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign vld_in  = vld_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign trial = (36'(root_in) << (K + 1)) + (36'd1 << (2 * K));
    assign fits  = {2'b00, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= fits ? 34'({2'b00, rem_in} - trial) : rem_in;
        root_q[j] <= fits ? (root_in | (RootW'(1) << K)) : root_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

// File: rtl/qslerp_vec.sv
// qslerp_vec: pipelined vectoring cordic, angle of (x, y) in Q.16 radians
// depends on qslerp_pkg
module qslerp_vec import qslerp_pkg::*; #(
  parameter int SideW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [16:0]            x_i,
  input  logic [16:0]            y_i,
  input  logic [SideW-1:0]       side_i,
  output logic                   valid_o,
  output logic signed [AngW-1:0] z_o,
  output logic [SideW-1:0]       side_o
);

  logic signed [AngW-1:0] x_q [CordicSteps];
  logic signed [AngW-1:0] y_q [CordicSteps];
  logic signed [AngW-1:0] z_q [CordicSteps];
  logic                   vld_q  [CordicSteps];
  logic [SideW-1:0]       side_q [CordicSteps];

  for (genvar j = 0; j < CordicSteps; j++) begin : g_step
    logic signed [AngW-1:0] x_in, y_in, z_in, x_d, y_d, z_d;
    logic                   vld_in;
    logic [SideW-1:0]       side_in;

    if (j == 0) begin : g_head
      assign x_in    = $signed(AngW'(x_i));
      assign y_in    = $signed(AngW'(y_i));
      assign z_in    = '0;
      assign vld_in  = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign x_in    = x_q[j-1];
      assign y_in    = y_q[j-1];
      assign z_in    = z_q[j-1];
      assign vld_in  = vld_q[j-1];
      assign side_in = side_q[j-1];
    end

    always_comb begin
      if (y_in > 0) begin
        x_d = x_in + (y_in >>> j);
        y_d = y_in - (x_in >>> j);
        z_d = z_in + atan_at(4'(j));
      end else begin
        x_d = x_in - (y_in >>> j);
        y_d = y_in + (x_in >>> j);
        z_d = z_in - atan_at(4'(j));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[j]    <= x_d;
        y_q[j]    <= y_d;
        z_q[j]    <= z_d;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[CordicSteps-1];
  assign z_o     = z_q[CordicSteps-1];
  assign side_o  = side_q[CordicSteps-1];

endmodule

// File: rtl/qslerp_sin.sv
// qslerp_sin: two-lane pipelined rotation cordic giving sine in Q.16
// depends on qslerp_pkg
module qslerp_sin import qslerp_pkg::*; #(
  parameter int SideW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [16:0]            arg_a_i,
  input  logic [16:0]            arg_b_i,
  input  logic [SideW-1:0]       side_i,
  output logic                   valid_o,
  output logic signed [AngW-1:0] sin_a_o,
  output logic signed [AngW-1:0] sin_b_o,
  output logic [SideW-1:0]       side_o
);

  logic signed [AngW-1:0] x_q [CordicSteps][2];
  logic signed [AngW-1:0] y_q [CordicSteps][2];
  logic signed [AngW-1:0] z_q [CordicSteps][2];
  logic                   vld_q  [CordicSteps];
  logic [SideW-1:0]       side_q [CordicSteps];

  for (genvar j = 0; j < CordicSteps; j++) begin : g_step
    logic             vld_in;
    logic [SideW-1:0] side_in;

    if (j == 0) begin : g_head
      assign vld_in  = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign side_in = side_q[j-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [AngW-1:0] x_in, y_in, z_in, x_d, y_d, z_d;

      if (j == 0) begin : g_head
        assign x_in = CordicGainInv;
        assign y_in = '0;
        assign z_in = $signed(AngW'((l == 0) ? arg_a_i : arg_b_i));
      end else begin : g_next
        assign x_in = x_q[j-1][l];
        assign y_in = y_q[j-1][l];
        assign z_in = z_q[j-1][l];
      end

      always_comb begin
        if (z_in >= 0) begin
          x_d = x_in - (y_in >>> j);
          y_d = y_in + (x_in >>> j);
          z_d = z_in - atan_at(4'(j));
        end else begin
          x_d = x_in + (y_in >>> j);
          y_d = y_in - (x_in >>> j);
          z_d = z_in + atan_at(4'(j));
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[j][l] <= x_d;
          y_q[j][l] <= y_d;
          z_q[j][l] <= z_d;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[CordicSteps-1];
  assign sin_a_o = y_q[CordicSteps-1][0];
  assign sin_b_o = y_q[CordicSteps-1][1];
  assign side_o  = side_q[CordicSteps-1];

endmodule

// File: rtl/qslerp_div.sv
// qslerp_div: two-lane pipelined restoring divider sharing one divisor
// depends on qslerp_pkg
module qslerp_div import qslerp_pkg::*; #(
  parameter int SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [QuoW-1:0]  num_a_i,
  input  logic [QuoW-1:0]  num_b_i,
  input  logic [16:0]      den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QuoW-1:0]  quo_a_o,
  output logic [QuoW-1:0]  quo_b_o,
  output logic [SideW-1:0] side_o
);

  logic [16:0]      rem_q [QuoW][2];
  logic [QuoW-1:0]  num_q [QuoW][2];
  logic [QuoW-1:0]  quo_q [QuoW][2];
  logic [16:0]      den_q  [QuoW];
  logic             vld_q  [QuoW];
  logic [SideW-1:0] side_q [QuoW];

  for (genvar j = 0; j < QuoW; j++) begin : g_step
    logic             vld_in;
    logic [16:0]      den_in;
    logic [SideW-1:0] side_in;

    if (j == 0) begin : g_head
      assign vld_in  = valid_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign den_in  = den_q[j-1];
      assign side_in = side_q[j-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [16:0]     rem_in;
      logic [QuoW-1:0] num_in, quo_in;
      logic [17:0]     trial;
      logic            ge;

      if (j == 0) begin : g_head
        assign rem_in = '0;
        assign num_in = (l == 0) ? num_a_i : num_b_i;
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[j-1][l];
        assign num_in = num_q[j-1][l];
        assign quo_in = quo_q[j-1][l];
      end

      assign trial = {rem_in, num_in[QuoW-1]};
      assign ge    = trial >= {1'b0, den_in};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j][l] <= ge ? 17'(trial - {1'b0, den_in}) : trial[16:0];
          num_q[j][l] <= num_in << 1;
          quo_q[j][l] <= {quo_in[QuoW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j]  <= den_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QuoW-1];
  assign quo_a_o = quo_q[QuoW-1][0];
  assign quo_b_o = quo_q[QuoW-1][1];
  assign side_o  = side_q[QuoW-1];

endmodule
